[sv/bgwc_pkg.sv]
// Package: shared types and constants for the box/gaussian window filter.
package bgwc_pkg;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_WIN = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic MODE_BOX   = 1'b0;
  localparam logic MODE_GAUSS = 1'b1;

  localparam int unsigned WIN_LIMIT = 11;
  localparam int unsigned WIN_LOW   = 3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  // Widest sum: 121 taps * 255 * 2^10 fits in 36 bits.
  localparam int unsigned SUM_W = 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   start;
    logic [SUM_W-1:0]       wsum;
    logic [3*SUM_W-1:0]     sums;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } div_rsp_t;

endpackage

[sv/bgwc_div.sv]
// Shared restoring divider: three channel sums by one weight sum, one bit a cycle.
module bgwc_div
  import bgwc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] num [3];
  logic [SUM_W-1:0] rem [3];
  logic [SUM_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done_q;
  logic [SUM_W:0]   trial [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem[i], num[i][SUM_W-1]} - {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_q <= 1'b0;
      cnt <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(SUM_W);
        den <= req.wsum;
        for (int i = 0; i < 3; i++) begin
          num[i] <= req.sums[i*SUM_W +: SUM_W];
          rem[i] <= '0;
        end
      end else if (busy) begin
        for (int i = 0; i < 3; i++) begin
          if (!trial[i][SUM_W]) begin
            rem[i] <= trial[i][SUM_W-1:0];
            num[i] <= {num[i][SUM_W-2:0], 1'b1};
          end else begin
            rem[i] <= {rem[i][SUM_W-2:0], num[i][SUM_W-1]};
            num[i] <= {num[i][SUM_W-2:0], 1'b0};
          end
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits land in num; channel order red, green, blue
  assign rsp.done  = done_q;
  assign rsp.red   = num[2][7:0];
  assign rsp.green = num[1][7:0];
  assign rsp.blue  = num[0][7:0];

endmodule

[sv/box_gaussian_window_convolution.sv]
// Top level: frame store, window walk and accumulation of the window filter.
//
//  channel | handshake        | payload
//  input   | in_valid/in_stall | opcode pixel_row pixel_col in_red in_green in_blue
//  output  | out_valid/out_stall | out_red out_green out_blue status
//  config  | cfg_we           | cfg_index cfg_data
//
// A write does not leave the idle state. A compute reads one tap a cycle from the
// single read port of the frame memory, then passes a drain state and the divider;
// the next transfer is taken only once the result has left the output register.
// An error result is valid the cycle after the transfer.
// Reset is synchronous; the frame store is not cleared. The input is stalled
// while a compute is in flight or a result waits in the output register.
module box_gaussian_window_convolution
  import bgwc_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WINDOW = 11
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [6:0] pixel_row,
  input  logic [6:0] pixel_col,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [1:0] status,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int WMAX = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;

  logic [7:0] image_width, image_height;
  logic [3:0] win_edge;
  logic       filter_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 8'd128;
      image_height <= 8'd128;
      win_edge <= 4'd3;
      filter_mode <= MODE_BOX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_WINDOW: win_edge <= cfg_data[3:0];
        REG_MODE:   filter_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes clamped to 1..MAX
  logic signed [13:0] w_eff, h_eff;
  always_comb begin
    if (image_width == 8'd0) w_eff = 14'sd1;
    else if ({6'd0, image_width} > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    else w_eff = 14'($signed({6'd0, image_width}));
    if (image_height == 8'd0) h_eff = 14'sd1;
    else if ({6'd0, image_height} > 14'(MAX_HEIGHT)) h_eff = 14'(MAX_HEIGHT);
    else h_eff = 14'($signed({6'd0, image_height}));
  end

  logic [23:0] mem [MAX_WIDTH*MAX_HEIGHT];
  logic [23:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {in_red, in_green, in_blue};
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  logic signed [5:0] dy, dx;
  logic signed [5:0] half;
  logic [7:0]  row_q, col_q;
  logic        last_tap;
  logic        rd_vld;
  logic [4:0]  sh_rd;
  logic [SUM_W-1:0] sr, sg, sb, wsum;
  logic [1:0]  res_status;
  logic [7:0]  res_r, res_g, res_b;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        started;

  bgwc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign mem_we = in_xfer && opcode == OP_WRITE && 32'(pixel_row) < MAX_HEIGHT
                  && 32'(pixel_col) < MAX_WIDTH;
  assign wr_addr = AW'((32'(pixel_row) * MAX_WIDTH) + 32'(pixel_col));

  logic win_bad, outside;
  assign win_bad = ({28'd0, win_edge} > 32'(WMAX)) || (win_edge < 4'(WIN_LOW))
                   || !win_edge[0];
  assign outside = ($signed({7'd0, pixel_row}) >= h_eff)
                   || ($signed({7'd0, pixel_col}) >= w_eff);

  function automatic logic signed [13:0] mirror(input logic signed [13:0] m,
                                               input logic signed [13:0] size);
    logic signed [13:0] v;
    v = m;
    if (v < 0) v = -v - 14'sd1;
    if (v >= size) v = 14'sd2 * size - 14'sd1 - v;
    if (v < 0) v = 14'sd0;
    if (v >= size) v = size - 14'sd1;
    return v;
  endfunction

  logic signed [13:0] mr, mc;
  logic [5:0] ady, adx;
  always_comb begin
    mr = mirror(14'($signed({6'd0, row_q})) + 14'(dy), h_eff);
    mc = mirror(14'($signed({6'd0, col_q})) + 14'(dx), w_eff);
    rd_addr = AW'((32'(mr) * MAX_WIDTH) + 32'(mc));
    ady = dy[5] ? 6'(-dy) : 6'(dy);
    adx = dx[5] ? 6'(-dx) : 6'(dx);
  end
  assign last_tap = (dy == half) && (dx == half);

  logic [4:0] sh_cur;
  assign sh_cur = 5'((half - 6'($signed(ady))) + (half - 6'($signed(adx))));

  always_comb begin
    state_next = state;
    dreq.start = started;
    dreq.wsum = wsum;
    dreq.sums = {sr, sg, sb};
    case (state)
      ST_IDLE:  if (in_xfer && opcode == OP_COMPUTE) state_next = (win_bad || outside)
                  ? ST_OUT : ST_ACC;
      ST_ACC:   if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (drsp.done) state_next = ST_OUT;
      end
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // divider starts once the last tap has landed in the sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_vld <= 1'b0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      rd_vld <= (state == ST_ACC);
      started <= (state == ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    sh_rd <= sh_cur;
    if (state == ST_IDLE && in_xfer) begin
      row_q <= {1'b0, pixel_row};
      col_q <= {1'b0, pixel_col};
      half <= 6'({2'd0, win_edge} >> 1);
      dy <= -6'({2'd0, win_edge} >> 1);
      dx <= -6'({2'd0, win_edge} >> 1);
      sr <= '0; sg <= '0; sb <= '0; wsum <= '0;
      res_status <= win_bad ? STATUS_BAD_WIN : (outside ? STATUS_OUTSIDE : STATUS_OK);
      res_r <= '0; res_g <= '0; res_b <= '0;
    end
    if (state == ST_ACC) begin
      if (dx == half) begin
        dx <= -half;
        dy <= dy + 6'sd1;
      end else begin
        dx <= dx + 6'sd1;
      end
    end
    if (rd_vld) begin
      if (filter_mode == MODE_GAUSS) begin
        sr <= sr + (SUM_W'(rd_data[23:16]) << sh_rd);
        sg <= sg + (SUM_W'(rd_data[15:8]) << sh_rd);
        sb <= sb + (SUM_W'(rd_data[7:0]) << sh_rd);
        wsum <= wsum + (SUM_W'(1) << sh_rd);
      end else begin
        sr <= sr + SUM_W'(rd_data[23:16]);
        sg <= sg + SUM_W'(rd_data[15:8]);
        sb <= sb + SUM_W'(rd_data[7:0]);
        wsum <= wsum + SUM_W'(1);
      end
    end
    if (drsp.done) begin
      res_r <= drsp.red;
      res_g <= drsp.green;
      res_b <= drsp.blue;
    end
  end

  assign out_valid = (state == ST_OUT);
  assign out_red = res_r;
  assign out_green = res_g;
  assign out_blue = res_b;
  assign status = res_status;

  ap_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC || state == ST_DIV) |-> in_stall)
    else $error("input taken while busy");
  ap_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_IDLE))
    else $error("store write while busy");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status)))
    else $error("result dropped under stall");

endmodule
